// File: hw/rtl/i2cbb_pkg.sv
package i2cbb_pkg;

	localparam int unsigned DELAY_W       = 16;
	localparam int unsigned TRIES_W       = 8;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned BITCNT_W      = 4;
	localparam int unsigned PHASE_W       = 3;
	localparam int unsigned IN_TDATA_W    = 16;
	localparam int unsigned OUT_TDATA_W   = 16;
	localparam int unsigned CFG_INDEX_W   = 1;

	localparam logic [DELAY_W-1:0]  DELAY_RESET   = DELAY_W'(20);
	localparam logic [TRIES_W-1:0]  TRIES_RESET   = TRIES_W'(5);
	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DELAY_TICKS = 1'b0,
		REG_ACK_TRIES   = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_WACK  = 3'd4,
		CMD_ACK   = 3'd5,
		CMD_NACK  = 3'd6,
		CMD_IDLE  = 3'd7
	} cmd_t;

	typedef struct packed {
		logic              sda_in;
		logic [BYTE_W-1:0] tx_byte;
		logic [2:0]        operation;
		logic              cmd_valid;
	} in_item_t;

	typedef struct packed {
		logic              ack_error;
		logic [BYTE_W-1:0] rx_byte;
		logic              done_res;
		logic              ready_res;
		logic              sda_drive_low;
		logic              scl_level;
	} res_item_t;

	typedef struct packed {
		logic [DELAY_W-1:0] delay_ticks;
		logic [TRIES_W-1:0] ack_tries;
	} cfg_t;

endpackage

// File: hw/rtl/i2cbb_ctrl.sv
module i2cbb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  i2cbb_pkg::in_item_t item,
	input  i2cbb_pkg::cfg_t     cfg,
	output i2cbb_pkg::res_item_t res
);
	import i2cbb_pkg::*;

	cmd_t                cmd_q, cmd_n;
	logic [PHASE_W-1:0]  phase_q, phase_n;
	logic [BITCNT_W-1:0] bits_q, bits_n;
	logic [BYTE_W-1:0]   shift_q, shift_n;
	logic [DELAY_W-1:0]  dcount_q, dcount_n;
	logic [TRIES_W-1:0]  tries_q, tries_n;
	logic                scl_q, scl_n;
	logic                sda_q, sda_n;
	logic [BYTE_W-1:0]   rx_q, rx_n;
	logic                done_n, err_n;
	logic [DELAY_W-1:0]  dly_ld;
	logic [BITCNT_W-1:0] bits_dec;
	cmd_t                op_cmd;

	assign dly_ld   = (cfg.delay_ticks == '0) ? '0 : cfg.delay_ticks - DELAY_W'(1);
	assign bits_dec = bits_q - BITCNT_W'(1);
	assign op_cmd   = cmd_t'(item.operation);

	// next state
	always_comb begin
		cmd_n    = cmd_q;
		phase_n  = phase_q;
		bits_n   = bits_q;
		shift_n  = shift_q;
		dcount_n = dcount_q;
		tries_n  = tries_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		rx_n     = rx_q;
		done_n   = 1'b0;
		err_n    = 1'b0;
		priority if (cmd_q == CMD_IDLE) begin
			if (item.cmd_valid && op_cmd != CMD_IDLE) begin
				cmd_n    = op_cmd;
				phase_n  = '0;
				dcount_n = dly_ld;
				unique case (op_cmd)
					CMD_START: sda_n = 1'b1;
					CMD_STOP:  scl_n = 1'b0;
					CMD_WRITE: begin
						shift_n = item.tx_byte;
						bits_n  = BITS_PER_BYTE;
						scl_n   = 1'b0;
					end
					CMD_READ: begin
						sda_n   = 1'b1;
						shift_n = '0;
						bits_n  = BITS_PER_BYTE;
						scl_n   = 1'b0;
					end
					CMD_WACK: begin
						sda_n   = 1'b1;
						tries_n = (cfg.ack_tries == '0) ? TRIES_W'(1) : cfg.ack_tries;
					end
					CMD_ACK: sda_n = 1'b0;
					default: sda_n = 1'b1;
				endcase
			end
		end else if (dcount_q != '0) begin
			dcount_n = dcount_q - DELAY_W'(1);
		end else begin
			// phase expired: advance the sequence, reload the delay
			dcount_n = dly_ld;
			phase_n  = phase_q + PHASE_W'(1);
			unique case (cmd_q)
				CMD_START: begin
					unique case (phase_q)
						3'd0:    scl_n = 1'b1;
						3'd1:    sda_n = 1'b0;
						3'd2:    scl_n = 1'b0;
						default: done_n = 1'b1;
					endcase
				end
				CMD_STOP: begin
					unique case (phase_q)
						3'd0:    sda_n = 1'b0;
						3'd1:    scl_n = 1'b1;
						3'd2:    sda_n = 1'b1;
						default: done_n = 1'b1;
					endcase
				end
				CMD_WRITE: begin
					unique case (phase_q)
						3'd0: begin
							sda_n   = shift_q[BYTE_W-1];
							shift_n = {shift_q[BYTE_W-2:0], 1'b0};
						end
						3'd1: ;
						3'd2: scl_n = 1'b1;
						3'd3: begin
							bits_n  = bits_dec;
							scl_n   = 1'b0;
							phase_n = (bits_dec != '0) ? PHASE_W'(0) : PHASE_W'(4);
						end
						default: done_n = 1'b1;
					endcase
				end
				CMD_READ: begin
					unique case (phase_q)
						3'd0: ;
						3'd1: scl_n = 1'b1;
						3'd2: begin
							shift_n = {shift_q[BYTE_W-2:0], item.sda_in};
							bits_n  = bits_dec;
							scl_n   = 1'b0;
							phase_n = (bits_dec != '0) ? PHASE_W'(0) : PHASE_W'(3);
						end
						default: begin
							rx_n   = shift_q;
							done_n = 1'b1;
						end
					endcase
				end
				CMD_WACK: begin
					unique case (phase_q)
						3'd0: scl_n = 1'b1;
						3'd1, 3'd2: begin
							priority if (phase_q == 3'd2 && tries_q == '0) begin
								scl_n   = 1'b0;
								phase_n = PHASE_W'(4);
							end else if (!item.sda_in) begin
								scl_n   = 1'b0;
								phase_n = PHASE_W'(3);
							end else begin
								tries_n = tries_q - TRIES_W'(1);
								phase_n = PHASE_W'(2);
							end
						end
						3'd3: done_n = 1'b1;
						3'd4: sda_n = 1'b0;
						3'd5: scl_n = 1'b1;
						3'd6: sda_n = 1'b1;
						default: begin
							done_n = 1'b1;
							err_n  = 1'b1;
						end
					endcase
				end
				default: begin
					// send ack / nack
					unique case (phase_q)
						3'd0:    ;
						3'd1:    scl_n = 1'b1;
						3'd2:    scl_n = 1'b0;
						default: done_n = 1'b1;
					endcase
				end
			endcase
			if (done_n) begin
				cmd_n    = CMD_IDLE;
				phase_n  = '0;
				dcount_n = '0;
			end
		end
	end

	// result fields, values after this tick
	always_comb begin
		res.scl_level     = scl_n;
		res.sda_drive_low = ~sda_n;
		res.ready_res     = (cmd_n == CMD_IDLE);
		res.done_res      = done_n;
		res.rx_byte       = rx_n;
		res.ack_error     = err_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q    <= CMD_IDLE;
			phase_q  <= '0;
			bits_q   <= '0;
			shift_q  <= '0;
			dcount_q <= '0;
			tries_q  <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			rx_q     <= '0;
		end else if (step_en) begin
			cmd_q    <= cmd_n;
			phase_q  <= phase_n;
			bits_q   <= bits_n;
			shift_q  <= shift_n;
			dcount_q <= dcount_n;
			tries_q  <= tries_n;
			scl_q    <= scl_n;
			sda_q    <= sda_n;
			rx_q     <= rx_n;
		end
	end

endmodule

// File: hw/rtl/i2c_bitbang_master_core.sv
// Byte-level I2C master stepped once per tick: every transaction on the slave stream is one
// tick (command offer plus sampled SDA) and yields exactly one transaction on the master
// stream with the SCL/SDA drive, ready, done, last read byte and ack error after that tick.
// One tick is taken every clock cycle while the slave side is not stalled; its result reaches
// the master side through the input register, then the step logic into the output register.
// Backpressure on the master side stalls the slave side only once both registers are full.
// Write delay_ticks and ack_tries through the config port only while no command is running.
module i2c_bitbang_master_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// cmd_valid, operation[2:0], tx_byte[7:0], sda_in, zero pad
	input  logic [i2cbb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// scl_level, sda_drive_low, ready_res, done_res, rx_byte[7:0], ack_error, zero pad
	output logic [i2cbb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                                 cfg_we,
	input  logic [i2cbb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [i2cbb_pkg::DELAY_W-1:0]        cfg_wdata
);
	import i2cbb_pkg::*;

	localparam int unsigned IN_ITEM_W  = $bits(in_item_t);
	localparam int unsigned RES_ITEM_W = $bits(res_item_t);

	in_item_t  item_s1;
	logic      valid_s1;
	res_item_t res_s2, res_c;
	logic      valid_s2;
	logic      adv;
	cfg_t      cfg_q;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_ticks <= DELAY_RESET;
			cfg_q.ack_tries   <= TRIES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DELAY_TICKS: cfg_q.delay_ticks <= cfg_wdata;
				default:         cfg_q.ack_tries   <= cfg_wdata[TRIES_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
		end
	end

	i2cbb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_c;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W-RES_ITEM_W){1'b0}}, res_s2};

endmodule

// File: hw/rtl/i2cbb_chk.sv
module i2cbb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under backpressure");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled while output side is empty");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
		else $error("done reported while not idle");

	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |->
		m_axis_tdata[3] && m_axis_tdata[0] && !m_axis_tdata[1])
		else $error("ack error without done and completed stop");

endmodule

bind i2c_bitbang_master_core i2cbb_chk u_i2cbb_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/i2c_bitbang_master_checker.sv
module i2c_bitbang_master_checker
	import i2cbb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	input  logic                      s_axis_tready,
	// cmd_valid, operation[2:0], tx_byte[7:0], sda_in, zero pad
	input  logic [IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// scl_level, sda_drive_low, ready_res, done_res, rx_byte[7:0], ack_error, zero pad
	input  logic [OUT_TDATA_W-1:0]    m_axis_tdata,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [DELAY_W-1:0]        cfg_wdata,
	output int unsigned               fail_count,
	output int unsigned               pending,
	output logic                      master_idle
);

	typedef enum logic [1:0] {
		STEP_RUN,
		STEP_DONE,
		STEP_ACK_FAIL
	} step_end_t;

	// shadow of the bus master
	cmd_t                cur_cmd;
	logic [PHASE_W-1:0]  phase;
	logic [BITCNT_W-1:0] bits_left;
	logic [BYTE_W-1:0]   shreg;
	logic [BYTE_W-1:0]   last_rx;
	logic [DELAY_W-1:0]  hold_cnt;
	logic [DELAY_W-1:0]  delay_cfg;
	logic [TRIES_W-1:0]  tries_left;
	logic [TRIES_W-1:0]  tries_cfg;
	logic                scl_q;
	logic                sda_rel;

	res_item_t tick_outcome_q[$];
	res_item_t seen_res;
	res_item_t want_res;

	initial fail_count = 0;

	// a zero delay behaves as a single tick
	function automatic void load_phase(input int unsigned ph);
		hold_cnt = (delay_cfg == '0) ? '0 : delay_cfg - 1'b1;
		phase    = PHASE_W'(ph);
	endfunction

	function automatic void poll_ack(input logic sda);
		if (!sda) begin
			scl_q = 1'b0;
			load_phase(3);
		end else begin
			tries_left = tries_left - 1'b1;
			load_phase(2);
		end
	endfunction

	function automatic void launch(input logic [BYTE_W-1:0] tx);
		case (cur_cmd)
			CMD_START: sda_rel = 1'b1;
			CMD_STOP:  scl_q = 1'b0;
			CMD_WRITE: begin
				shreg     = tx;
				bits_left = BITS_PER_BYTE;
				scl_q     = 1'b0;
			end
			CMD_READ: begin
				sda_rel   = 1'b1;
				shreg     = '0;
				bits_left = BITS_PER_BYTE;
				scl_q     = 1'b0;
			end
			CMD_WACK: begin
				sda_rel    = 1'b1;
				tries_left = (tries_cfg == '0) ? TRIES_W'(1) : tries_cfg;
			end
			CMD_ACK:   sda_rel = 1'b0;
			default:   sda_rel = 1'b1;
		endcase
		load_phase(0);
	endfunction

	function automatic step_end_t finish_phase(input logic sda);
		step_end_t fin;
		fin = STEP_RUN;
		case (cur_cmd)
			CMD_START: begin
				case (phase)
					0: begin scl_q = 1'b1; load_phase(1); end
					1: begin sda_rel = 1'b0; load_phase(2); end
					2: begin scl_q = 1'b0; load_phase(3); end
					default: fin = STEP_DONE;
				endcase
			end
			CMD_STOP: begin
				case (phase)
					0: begin sda_rel = 1'b0; load_phase(1); end
					1: begin scl_q = 1'b1; load_phase(2); end
					2: begin sda_rel = 1'b1; load_phase(3); end
					default: fin = STEP_DONE;
				endcase
			end
			CMD_WRITE: begin
				case (phase)
					0: begin
						sda_rel = shreg[BYTE_W-1];
						shreg   = shreg << 1;
						load_phase(1);
					end
					1: load_phase(2);
					2: begin scl_q = 1'b1; load_phase(3); end
					3: begin
						bits_left = bits_left - 1'b1;
						scl_q     = 1'b0;
						load_phase((bits_left != '0) ? 0 : 4);
					end
					default: fin = STEP_DONE;
				endcase
			end
			CMD_READ: begin
				case (phase)
					0: load_phase(1);
					1: begin scl_q = 1'b1; load_phase(2); end
					2: begin
						// sample SDA as the high phase ends
						shreg     = {shreg[BYTE_W-2:0], sda};
						bits_left = bits_left - 1'b1;
						scl_q     = 1'b0;
						load_phase((bits_left != '0) ? 0 : 3);
					end
					default: begin
						last_rx = shreg;
						fin     = STEP_DONE;
					end
				endcase
			end
			CMD_WACK: begin
				case (phase)
					0: begin scl_q = 1'b1; load_phase(1); end
					1: poll_ack(sda);
					2: begin
						// out of tries: fall into the stop sequence
						if (tries_left == '0) begin
							scl_q = 1'b0;
							load_phase(4);
						end else begin
							poll_ack(sda);
						end
					end
					3: fin = STEP_DONE;
					4: begin sda_rel = 1'b0; load_phase(5); end
					5: begin scl_q = 1'b1; load_phase(6); end
					6: begin sda_rel = 1'b1; load_phase(7); end
					default: fin = STEP_ACK_FAIL;
				endcase
			end
			default: begin
				case (phase)
					0: load_phase(1);
					1: begin scl_q = 1'b1; load_phase(2); end
					2: begin scl_q = 1'b0; load_phase(3); end
					default: fin = STEP_DONE;
				endcase
			end
		endcase
		return fin;
	endfunction

	function automatic res_item_t step_master(input in_item_t it);
		res_item_t r;
		step_end_t fin;
		fin = STEP_RUN;
		if (cur_cmd == CMD_IDLE) begin
			if (it.cmd_valid && cmd_t'(it.operation) != CMD_IDLE) begin
				cur_cmd = cmd_t'(it.operation);
				launch(it.tx_byte);
			end
		end else if (hold_cnt != '0) begin
			hold_cnt = hold_cnt - 1'b1;
		end else begin
			fin = finish_phase(it.sda_in);
			if (fin != STEP_RUN) begin
				cur_cmd  = CMD_IDLE;
				phase    = '0;
				hold_cnt = '0;
			end
		end
		r.scl_level     = scl_q;
		r.sda_drive_low = ~sda_rel;
		r.ready_res     = (cur_cmd == CMD_IDLE);
		r.done_res      = (fin != STEP_RUN);
		r.rx_byte       = last_rx;
		r.ack_error     = (fin == STEP_ACK_FAIL);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cmd    = CMD_IDLE;
			phase      = '0;
			bits_left  = '0;
			shreg      = '0;
			last_rx    = '0;
			hold_cnt   = '0;
			tries_left = '0;
			scl_q      = 1'b1;
			sda_rel    = 1'b1;
			delay_cfg  = DELAY_RESET;
			tries_cfg  = TRIES_RESET;
			tick_outcome_q.delete();
			pending     <= 0;
			master_idle <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELAY_TICKS: delay_cfg = cfg_wdata;
					REG_ACK_TRIES:   tries_cfg = cfg_wdata[TRIES_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen_res = res_item_t'(m_axis_tdata[$bits(res_item_t)-1:0]);
				if (tick_outcome_q.size() == 0) begin
					$error("unexpected output transaction 0x%0h", seen_res);
					fail_count++;
				end else begin
					want_res = tick_outcome_q.pop_front();
					check_field("scl_level", BYTE_W'(want_res.scl_level),
						BYTE_W'(seen_res.scl_level));
					check_field("sda_drive_low", BYTE_W'(want_res.sda_drive_low),
						BYTE_W'(seen_res.sda_drive_low));
					check_field("ready_res", BYTE_W'(want_res.ready_res),
						BYTE_W'(seen_res.ready_res));
					check_field("done_res", BYTE_W'(want_res.done_res),
						BYTE_W'(seen_res.done_res));
					check_field("rx_byte", want_res.rx_byte, seen_res.rx_byte);
					check_field("ack_error", BYTE_W'(want_res.ack_error),
						BYTE_W'(seen_res.ack_error));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				tick_outcome_q.push_back(
					step_master(in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0])));
			pending     <= tick_outcome_q.size();
			master_idle <= (cur_cmd == CMD_IDLE);
		end
	end

endmodule

// File: tb/sv/tb_i2c_bitbang_master_core.sv
module tb_i2c_bitbang_master_core;
	import i2cbb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400_000;
	localparam int unsigned ITEM_TARGET = 850;
	localparam int unsigned ROUND_ITEMS = 60;

	logic                    clk;
	logic                    arst_n        = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	// cmd_valid, operation[2:0], tx_byte[7:0], sda_in, zero pad
	logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	// scl_level, sda_drive_low, ready_res, done_res, rx_byte[7:0], ack_error, zero pad
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;
	logic                    cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0]  cfg_index     = REG_DELAY_TICKS;
	logic [DELAY_W-1:0]      cfg_wdata     = '0;

	int unsigned fail_count;
	int unsigned pending;
	logic        master_idle;

	int unsigned cycle_count   = 0;
	int unsigned items_sent    = 0;
	int unsigned rx_stall      = 0;
	bit          rx_calm       = 1'b0;
	bit          tx_calm       = 1'b0;
	bit          noise_on      = 1'b1;

	i2c_bitbang_master_core dut (.*);

	i2c_bitbang_master_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_i2c_bitbang_master_core NOT OK");
			$finish;
		end
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic sda_level(input int unsigned hi_pct);
		return ($urandom_range(0, 99) < hi_pct);
	endfunction

	function automatic int unsigned ack_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 20;
			2: return 60;
			default: return 100;
		endcase
	endfunction

	always @(posedge clk) begin
		if (rx_stall != 0) begin
			m_axis_tready <= 1'b0;
			rx_stall--;
		end else begin
			m_axis_tready <= 1'b1;
			if (!rx_calm)
				rx_stall = pick_gap();
		end
		if ($urandom_range(0, 199) == 0)
			rx_calm = !rx_calm;
	end

	task automatic send_tick(input in_item_t it);
		int unsigned gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - $bits(in_item_t)){1'b0}}, it};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if ($urandom_range(0, 199) == 0)
			tx_calm = !tx_calm;
	endtask

	// offer one command, then tick until the master is idle again
	task automatic run_command(input cmd_t op, input logic [BYTE_W-1:0] tx,
			input int unsigned hi_pct);
		in_item_t it;
		bit       drained;
		it.cmd_valid = 1'b1;
		it.operation = op;
		it.tx_byte   = tx;
		it.sda_in    = sda_level(hi_pct);
		send_tick(it);
		do begin
			// occasional commands while busy must be dropped
			it.cmd_valid = noise_on && ($urandom_range(0, 99) < 3);
			it.operation = 3'($urandom_range(0, 7));
			it.tx_byte   = BYTE_W'($urandom);
			it.sda_in    = sda_level(hi_pct);
			send_tick(it);
			// idle flag reflects the tick before this one
			drained = master_idle && !it.cmd_valid;
		end while (!drained);
	endtask

	task automatic run_transfer();
		logic [BYTE_W-1:0] addr;
		int unsigned       n;
		addr = BYTE_W'($urandom);
		n    = $urandom_range(0, 3);
		run_command(CMD_START, BYTE_W'($urandom), 50);
		run_command(CMD_WRITE, addr, 50);
		run_command(CMD_WACK, BYTE_W'($urandom), ack_pct());
		for (int i = 0; i < n; i++) begin
			if (addr[0]) begin
				run_command(CMD_READ, BYTE_W'($urandom), $urandom_range(0, 100));
				run_command((i == n - 1) ? CMD_NACK : CMD_ACK, BYTE_W'($urandom), 50);
			end else begin
				run_command(CMD_WRITE, BYTE_W'($urandom), 50);
				run_command(CMD_WACK, BYTE_W'($urandom), ack_pct());
			end
		end
		// leave out the stop now and then for a repeated start
		if ($urandom_range(0, 9) != 0)
			run_command(CMD_STOP, BYTE_W'($urandom), 50);
	endtask

	task automatic set_config(input logic [DELAY_W-1:0] dly, input logic [TRIES_W-1:0] tries);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DELAY_TICKS;
		cfg_wdata <= dly;
		@(posedge clk);
		cfg_index <= REG_ACK_TRIES;
		cfg_wdata <= DELAY_W'(tries);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned base;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timing on a short command, then an operation that is ignored
		noise_on = 1'b0;
		run_command(CMD_START, 8'h00, 50);
		noise_on = 1'b1;
		run_command(CMD_IDLE, 8'hFF, 50);

		// zero delay and zero tries: every operation, byte extremes, ack and ack failure
		set_config('0, '0);
		run_command(CMD_START, 8'h00, 50);
		run_command(CMD_WRITE, 8'hFF, 50);
		run_command(CMD_WACK, 8'h00, 0);
		run_command(CMD_WRITE, 8'h00, 50);
		run_command(CMD_WACK, 8'h00, 100);
		run_command(CMD_START, 8'h00, 50);
		run_command(CMD_WRITE, 8'hA5, 50);
		run_command(CMD_WACK, 8'h00, 50);
		run_command(CMD_READ, 8'h00, 50);
		run_command(CMD_ACK, 8'h00, 50);
		run_command(CMD_READ, 8'h00, 100);
		run_command(CMD_ACK, 8'h00, 50);
		run_command(CMD_READ, 8'h00, 0);
		run_command(CMD_NACK, 8'h00, 50);
		run_command(CMD_STOP, 8'h00, 50);
		run_command(CMD_IDLE, 8'h00, 50);

		// most tries with the shortest delay
		set_config(DELAY_W'(1), '1);
		run_command(CMD_START, 8'h00, 50);
		run_command(CMD_WACK, 8'h00, 100);
		run_command(CMD_STOP, 8'h00, 50);

		while (items_sent < ITEM_TARGET) begin
			set_config(DELAY_W'($urandom_range(0, 2)), TRIES_W'($urandom_range(0, 6)));
			base = items_sent;
			while (items_sent - base < ROUND_ITEMS && items_sent < ITEM_TARGET) begin
				if ($urandom_range(0, 99) < 80)
					run_transfer();
				else
					run_command(cmd_t'($urandom_range(0, 7)), BYTE_W'($urandom),
						$urandom_range(0, 100));
			end
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb_i2c_bitbang_master_core OK");
		else
			$display("tb_i2c_bitbang_master_core NOT OK");
		$finish;
	end

endmodule
